/* hdl/irbm_pkg.sv */
// Package for the IR remote button mask decoder.
// Holds beat layouts, frame codes, the key table and pad bit placement.
// No dependencies.
package irbm_pkg;

  localparam int MaskW     = 33;
  localparam int InDataW   = 72;
  localparam int InUserW   = 3;
  localparam int OutDataW  = 48;
  localparam int TimeoutW  = 16;
  localparam int PadOffset = 27;

  localparam logic [1:0]  KIND_REMOTE   = 2'd0;
  localparam logic [1:0]  KIND_NEC      = 2'd1;
  localparam logic [5:0]  BITS_FRAME    = 6'd24;
  localparam logic [5:0]  BITS_REMOTE_RPT = 6'd4;
  localparam logic [5:0]  BITS_NEC_RPT  = 6'd0;
  localparam logic [31:0] CODE_NEC_RPT  = 32'hFFFF_FFFF;
  localparam logic [31:0] CODE_REMOTE_RPT = 32'h00FF_FFFF;
  localparam logic [1:0]  PAD_MARK      = 2'b11;
  localparam logic [TimeoutW-1:0] TIMEOUT_RESET = 16'd100;

  typedef struct packed {
    logic        present;
    logic [1:0]  kind;
    logic [5:0]  bit_count;
    logic [31:0] code;
    logic [31:0] now_ms;
  } in_beat_t;

  typedef struct packed {
    logic             load_mask;
    logic             refresh;
    logic [MaskW-1:0] mask;
  } frame_dec_t;

  function automatic logic [MaskW-1:0] key_bit(input logic [4:0] pos);
    key_bit = MaskW'(1) << pos;
  endfunction

  function automatic logic [MaskW-1:0] remote_key_mask(input logic [31:0] code);
    case (code)
      32'h0000_1ffe: remote_key_mask = key_bit(5'd6);
      32'h0002_1fde: remote_key_mask = key_bit(5'd7);
      32'h0001_1fee: remote_key_mask = key_bit(5'd8);
      32'h0000_9ff6: remote_key_mask = key_bit(5'd9);
      32'h0002_9fd6: remote_key_mask = key_bit(5'd10);
      32'h0001_9fe6: remote_key_mask = key_bit(5'd11);
      32'h0000_5ffa: remote_key_mask = key_bit(5'd12);
      32'h0002_5fda: remote_key_mask = key_bit(5'd13);
      32'h0001_5fea: remote_key_mask = key_bit(5'd14);
      32'h0003_9fc6: remote_key_mask = key_bit(5'd15);
      32'h0003_1fce: remote_key_mask = key_bit(5'd16);
      32'h0003_5fca: remote_key_mask = key_bit(5'd17);
      32'h0002_2fdd: remote_key_mask = key_bit(5'd18);
      32'h0000_2ffd: remote_key_mask = key_bit(5'd19);
      32'h0001_2fed: remote_key_mask = key_bit(5'd20);
      32'h0003_2fcd: remote_key_mask = key_bit(5'd21);
      32'h0000_aff5: remote_key_mask = key_bit(5'd22);
      32'h0001_afe5: remote_key_mask = key_bit(5'd23);
      32'h0002_afd5: remote_key_mask = key_bit(5'd24);
      32'h0000_6ff9: remote_key_mask = key_bit(5'd25);
      32'h0003_afc5: remote_key_mask = key_bit(5'd26);
      default:       remote_key_mask = '0;
    endcase
  endfunction

  function automatic logic [MaskW-1:0] pad_key_mask(input logic [31:0] code);
    logic [5:0] pad;
    pad = ~{code[7], code[6], code[4], code[2], code[5], code[3]};
    if (code[11]) pad_key_mask = MaskW'(pad);
    else          pad_key_mask = MaskW'(pad) << PadOffset;
  endfunction

endpackage

/* hdl/irbm_frame_decode.sv */
// Frame classifier for the IR remote button mask decoder.
// Sorts a registered beat into data, repeat or ignored, and forms its mask.
// Depends on irbm_pkg.
module irbm_frame_decode (
  input  irbm_pkg::in_beat_t   beat,
  output irbm_pkg::frame_dec_t dec
);

  logic is_data;
  logic is_repeat;

  assign is_data = (beat.kind == irbm_pkg::KIND_REMOTE) &&
                   (beat.bit_count == irbm_pkg::BITS_FRAME);

  assign is_repeat =
    ((beat.kind == irbm_pkg::KIND_NEC) && (beat.bit_count == irbm_pkg::BITS_NEC_RPT) &&
     (beat.code == irbm_pkg::CODE_NEC_RPT)) ||
    ((beat.kind == irbm_pkg::KIND_REMOTE) && (beat.bit_count == irbm_pkg::BITS_REMOTE_RPT) &&
     (beat.code == irbm_pkg::CODE_REMOTE_RPT));

  always_comb begin
    dec.load_mask = is_data;
    dec.refresh   = is_data || is_repeat;
    if (beat.code[1:0] == irbm_pkg::PAD_MARK) dec.mask = irbm_pkg::pad_key_mask(beat.code);
    else                                       dec.mask = irbm_pkg::remote_key_mask(beat.code);
  end

endmodule

/* hdl/irbm_input_stage.sv */
// Input register for the IR remote button mask decoder.
// Unpacks slave beats into one registered beat and handles backpressure.
// Depends on irbm_pkg.
module irbm_input_stage (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [irbm_pkg::InDataW-1:0] s_tdata,
  input  logic [irbm_pkg::InUserW-1:0] s_tuser,
  input  logic                         advance,
  output logic                         beat_valid,
  output irbm_pkg::in_beat_t           beat
);

  assign s_tready = advance || !beat_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (s_tready) begin
      beat_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      beat.present   <= s_tuser[0];
      beat.kind      <= s_tuser[2:1];
      beat.bit_count <= s_tdata[5:0];
      beat.code      <= s_tdata[37:6];
      beat.now_ms    <= s_tdata[69:38];
    end
  end

endmodule

/* hdl/irbm_hold_stage.sv */
// Hold state, timeout and checksum stage of the IR remote button mask decoder.
// Updates held mask and frame time, drives the master output register.
// Depends on irbm_pkg.
module irbm_hold_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [irbm_pkg::TimeoutW-1:0] cfg_wdata,
  input  logic                          beat_valid,
  input  irbm_pkg::in_beat_t            beat,
  input  irbm_pkg::frame_dec_t          dec,
  output logic                          advance,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [irbm_pkg::OutDataW-1:0] m_tdata
);

  logic [irbm_pkg::TimeoutW-1:0] hold_timeout;
  logic [irbm_pkg::MaskW-1:0]    held_mask;
  logic [irbm_pkg::MaskW-1:0]    held_mask_next;
  logic [31:0]                   last_frame_time;
  logic [31:0]                   last_frame_time_next;
  logic [31:0]                   elapsed;
  logic [5:0]                    count;
  logic                          fire;

  assign advance = !m_tvalid || m_tready;
  assign fire    = advance && beat_valid;
  assign elapsed = beat.now_ms - last_frame_time;

  always_comb begin
    held_mask_next       = held_mask;
    last_frame_time_next = last_frame_time;
    if (beat.present) begin
      if (dec.load_mask) held_mask_next = dec.mask;
      if (dec.refresh)   last_frame_time_next = beat.now_ms;
    end else if (elapsed >= {16'b0, hold_timeout}) begin
      held_mask_next = '0;
    end
    count = 6'($countones(held_mask_next));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_timeout <= irbm_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      hold_timeout <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_mask       <= '0;
      last_frame_time <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      if (fire) begin
        held_mask       <= held_mask_next;
        last_frame_time <= last_frame_time_next;
      end
      if (advance) m_tvalid <= beat_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {1'b0, count[5:4], 4'b0, count[3:0], 4'b0, held_mask_next};
    end
  end

endmodule

/* hdl/ir_remote_button_mask_decoder.sv */
// Top level of the IR remote button mask decoder.
// Each slave beat is one poll: optional decoded IR frame plus timestamp.
// Each poll yields one master beat: the held 33-bit button mask and two
// popcount checksum bytes.
// Slave tuser [0] frame_present, [2:1] frame_kind. Slave tdata [5:0]
// bit_count, [37:6] code, [69:38] now_ms, [71:70] zero.
// Master tdata [32:0] button_mask, [40:33] checksum_low_byte,
// [46:41] checksum_high_byte, [47] zero.
// cfg_we/cfg_wdata write hold_timeout_ms; write only when idle.
// A slave beat passes an input register, then lookup, remap, timeout
// compare and popcount into the output register. Throughput is one beat
// per cycle unless the master stalls, set by the single hold-state update.
// Reset clears the mask, frame time and both valid flags and sets the
// timeout to 100 ms. A stalled master holds its beat; the input register
// still takes one more beat, then s_tready drops until the stall ends.
// Depends on irbm_pkg and the irbm stage modules.
module ir_remote_button_mask_decoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [irbm_pkg::TimeoutW-1:0] cfg_wdata,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [irbm_pkg::InDataW-1:0]  s_tdata,  // bit_count, code, now_ms
  input  logic [irbm_pkg::InUserW-1:0]  s_tuser,  // frame_present, frame_kind
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [irbm_pkg::OutDataW-1:0] m_tdata   // button_mask, low byte, high byte
);

  logic                 advance;
  logic                 beat_valid;
  irbm_pkg::in_beat_t   beat;
  irbm_pkg::frame_dec_t dec;

  irbm_input_stage u_input (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .advance    (advance),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  irbm_frame_decode u_decode (
    .beat (beat),
    .dec  (dec)
  );

  irbm_hold_stage u_hold (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .beat_valid (beat_valid),
    .beat       (beat),
    .dec        (dec),
    .advance    (advance),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

/* hdl/irbm_checker.sv */
// Port-level checker for the IR remote button mask decoder.
// Bound to the top level; watches handshakes and checksum fields.
// Depends on irbm_pkg.
module irbm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [irbm_pkg::OutDataW-1:0] m_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  a_checksum: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($countones(m_tdata[32:0]) ==
                  {26'b0, m_tdata[46:45], m_tdata[40:37]}))
    else $error("checksum does not match mask");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output beat changed");

endmodule

bind ir_remote_button_mask_decoder irbm_checker u_irbm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
